// File: hw/rtl/vnorm_pkg.sv
// Package for the vector normalizer: widths, sizes and the controller/datapath
// command and status structs. No dependencies.
package vnorm_pkg;
    localparam int MaxLen    = 64;
    localparam int ElemBits  = 16;
    localparam int FracBits  = ElemBits - 1;
    localparam int AddrBits  = 6;
    localparam int CountBits = 7;
    localparam int SumBits   = 37;
    localparam int RootBits  = 19;
    localparam int InvBits   = 31;
    localparam int DivBits   = 2 * FracBits + 1;

    typedef struct packed {
        logic load;      // store element, add its square
        logic root_go;   // start square root
        logic div_go;    // start reciprocal division
        logic rd_go;     // latch sum-is-zero flag for scaling
        logic emit_cap;  // capture scaled product into output register
        logic clear;     // reset sum for next vector
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic div_done;
        logic sum_zero;
    } t_status;
endpackage

// File: hw/rtl/vnorm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module vnorm_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/vnorm_datapath.sv
// Datapath: element store, sum of squares, iterative square root and divider,
// scaling multiplier. Depends on vnorm_pkg and vnorm_ram.
module vnorm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vnorm_pkg::t_cmd                   i_cmd,
    input  logic [vnorm_pkg::AddrBits-1:0]    i_waddr,
    input  logic [vnorm_pkg::AddrBits-1:0]    i_raddr,
    input  logic signed [vnorm_pkg::ElemBits-1:0] i_sample,
    output vnorm_pkg::t_status                o_status,
    output logic signed [vnorm_pkg::ElemBits-1:0] o_scaled
);
    localparam int EB = vnorm_pkg::ElemBits;
    localparam int SB = vnorm_pkg::SumBits;
    localparam int RB = vnorm_pkg::RootBits;
    localparam int DB = vnorm_pkg::DivBits;
    localparam int IB = vnorm_pkg::InvBits;
    localparam int FB = vnorm_pkg::FracBits;

    logic [SB-1:0]   r_sum;
    logic [EB-1:0]   w_mag_in;
    logic [2*EB-1:0] w_sq;

    assign w_mag_in = i_sample[EB-1] ? EB'(-i_sample) : EB'(i_sample);
    assign w_sq     = w_mag_in * w_mag_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum <= '0;
        end else if (i_cmd.load) begin
            r_sum <= r_sum + SB'(w_sq);
        end
    end

    logic [EB-1:0] w_rdata;
    vnorm_ram #(.Width(EB), .Depth(vnorm_pkg::MaxLen)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_waddr(i_waddr),
        .i_wdata(i_sample),
        .i_raddr(i_raddr),
        .o_rdata(w_rdata)
    );

    // Restoring square root, one result bit per cycle. The radicand is padded
    // to an even width so that bit pairs line up with the binary point.
    logic [SB+1:0] r_rem;
    logic [RB-1:0] r_root;
    logic [SB:0]   r_rad;
    logic [4:0]    r_rcnt;
    logic          r_rbusy;
    logic [SB+1:0] w_rem_sh;
    logic [SB+1:0] w_trial;

    assign w_rem_sh = {r_rem[SB-1:0], r_rad[SB:SB-1]};
    assign w_trial  = (SB+2)'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbusy <= 1'b0;
            r_rcnt  <= '0;
        end else if (i_cmd.root_go) begin
            r_rbusy <= 1'b1;
            r_rcnt  <= 5'(RB);
            r_rem   <= '0;
            r_root  <= '0;
            r_rad   <= {1'b0, r_sum};
        end else if (r_rbusy) begin
            r_rad <= {r_rad[SB-2:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[RB-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[RB-2:0], 1'b0};
            end
            r_rcnt <= r_rcnt - 5'd1;
            if (r_rcnt == 5'd1) begin
                r_rbusy <= 1'b0;
            end
        end
    end

    // Restoring divider: 2^30 / root, one quotient bit per cycle.
    logic [RB:0]   r_drem;
    logic [DB-1:0] r_quot;
    logic [5:0]    r_dcnt;
    logic          r_dbusy;
    logic [RB:0]   w_dsh;

    assign w_dsh = {r_drem[RB-1:0], r_quot[DB-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_go) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= 6'(DB);
            r_drem  <= '0;
            r_quot  <= DB'(1) << (2 * FB);
        end else if (r_dbusy) begin
            if (w_dsh >= {1'b0, r_root}) begin
                r_drem <= w_dsh - {1'b0, r_root};
                r_quot <= {r_quot[DB-2:0], 1'b1};
            end else begin
                r_drem <= w_dsh;
                r_quot <= {r_quot[DB-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 6'd1;
            if (r_dcnt == 6'd1) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    // Scaling: |v| * inv, registered, round, sign, saturate; raw if sum is 0.
    logic          r_neg;
    logic [EB+IB-1:0] r_prod;
    logic [EB-1:0] r_raw;
    logic          r_zero;
    logic [EB-1:0] w_mag;
    logic [EB+IB-1:0] w_q;
    logic [EB-1:0] w_res;

    assign w_mag = w_rdata[EB-1] ? EB'(-w_rdata) : w_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_go) begin
            r_zero <= (r_sum == '0);
        end
        r_neg  <= w_rdata[EB-1];
        r_raw  <= w_rdata;
        r_prod <= w_mag * r_quot[IB-1:0];
    end

    always_comb begin
        w_q = (r_prod + ((EB+IB)'(1) << (FB - 1))) >> FB;
        if (r_zero) begin
            w_res = r_raw;
        end else if (r_neg) begin
            w_res = (w_q > ((EB+IB)'(1) << FB)) ? {1'b1, {(EB-1){1'b0}}}
                                                : EB'(-w_q);
        end else begin
            w_res = (w_q > (EB+IB)'({(FB){1'b1}})) ? {1'b0, {(EB-1){1'b1}}}
                                                    : EB'(w_q);
        end
    end

    logic [EB-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cap) begin
            r_out <= w_res;
        end
    end

    assign o_scaled            = r_out;
    assign o_status.root_done  = !r_rbusy && !i_cmd.root_go;
    assign o_status.div_done   = !r_dbusy && !i_cmd.div_go;
    assign o_status.sum_zero   = (r_sum == '0);
endmodule

// File: hw/rtl/vnorm_ctrl.sv
// Controller state machine for the vector normalizer: load, root, divide,
// emit. Depends on vnorm_pkg.
module vnorm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_final,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_end_of_run,
    output logic                           o_zero_vector,
    input  vnorm_pkg::t_status             i_status,
    output vnorm_pkg::t_cmd                o_cmd,
    output logic [vnorm_pkg::AddrBits-1:0] o_waddr,
    output logic [vnorm_pkg::AddrBits-1:0] o_raddr
);
    localparam int CB = vnorm_pkg::CountBits;
    localparam int AB = vnorm_pkg::AddrBits;

    typedef enum logic [2:0] {
        S_LOAD, S_ROOT, S_DIV, S_READ, S_MUL, S_CAP, S_SHOW
    } t_state;

    t_state        r_state;
    logic [CB-1:0] r_count;
    logic [CB-1:0] r_idx;
    logic          r_valid;
    logic          r_zero;
    logic          r_last;
    logic          w_acc;
    logic          w_end;
    logic          w_wait;

    assign o_in_ready = (r_state == S_LOAD);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_end      = i_final || (r_count == CB'(vnorm_pkg::MaxLen - 1));
    // Root start needs no extra hold-off; the sum already includes the last square.
    assign w_wait     = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_zero  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        r_count <= r_count + CB'(1);
                        if (w_end) begin
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    r_zero <= i_status.sum_zero;
                    if (i_status.sum_zero) begin
                        r_state <= S_READ;
                    end else if (i_status.root_done && !w_wait) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_MUL;
                S_MUL:  r_state <= S_CAP;
                S_CAP: begin
                    r_valid <= 1'b1;
                    r_last  <= (r_idx + CB'(1) == r_count);
                    r_state <= S_SHOW;
                end
                S_SHOW: begin
                    if (i_out_ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_idx   <= '0;
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + CB'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Delayed root start: the root starts on the first S_ROOT cycle,
    // after the last square is in the sum; done is seen from the next cycle.
    logic r_root_started;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_started <= 1'b0;
        end else begin
            r_root_started <= (r_state == S_ROOT);
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_acc;
        o_cmd.root_go  = (r_state == S_ROOT) && !r_root_started;
        o_cmd.div_go   = (r_state == S_ROOT) && r_root_started && i_status.root_done
                         && !i_status.sum_zero;
        o_cmd.rd_go    = (r_state == S_READ);
        o_cmd.emit_cap = (r_state == S_CAP);
        o_cmd.clear    = (r_state == S_SHOW) && i_out_ready && r_last;
    end

    assign o_waddr       = r_count[AB-1:0];
    assign o_raddr       = r_idx[AB-1:0];
    assign o_out_valid   = r_valid;
    assign o_end_of_run  = r_last;
    assign o_zero_vector = r_zero;

    a_valid_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_SHOW))
        else $error("output valid outside show state");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_out_valid)
        else $error("load while result pending");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(vnorm_pkg::MaxLen))
        else $error("fill count beyond depth");
endmodule

// File: hw/rtl/vector_normalize.sv
// Top level of the L2 vector normalizer: joins the controller and datapath.
// Depends on vnorm_pkg, vnorm_ctrl and vnorm_datapath.
//
//   channel | handshake             | words
//   in      | i_in_valid/o_in_ready | i_sample, i_final_req
//   out     | o_out_valid/i_out_ready| o_scaled, o_end_of_run, o_zero_vector
//
// Each element is stored and its square summed when accepted. At the end of a
// vector a bit-serial square root and a bit-serial divider run; an all-zero
// vector emits without waiting for either. Each element is then read,
// multiplied and registered in S_READ, S_MUL and S_CAP and shown in S_SHOW.
// Reset is synchronous and active low and returns the controller to loading.
// Input is refused while a vector is being computed or emitted; a stalled
// output word holds until taken.
module vector_normalize (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [vnorm_pkg::ElemBits-1:0] i_sample,
    input  logic                               i_final_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [vnorm_pkg::ElemBits-1:0] o_scaled,
    output logic                               o_end_of_run,
    output logic                               o_zero_vector
);
    vnorm_pkg::t_cmd                   w_cmd;
    vnorm_pkg::t_status                w_status;
    logic [vnorm_pkg::AddrBits-1:0]    w_waddr;
    logic [vnorm_pkg::AddrBits-1:0]    w_raddr;

    // The controller sequences loading, root, division and the emit loop.
    vnorm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_final      (i_final_req),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_end_of_run (o_end_of_run),
        .o_zero_vector(o_zero_vector),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_waddr      (w_waddr),
        .o_raddr      (w_raddr)
    );

    // The datapath holds the element store and all arithmetic.
    vnorm_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .i_sample(i_sample),
        .o_status(w_status),
        .o_scaled(o_scaled)
    );
endmodule
